/* rtl/core/s3i_pkg.sv */
// Shared types and constants for the symmetric 3x3 inverse pipeline.
// No dependencies; every other file depends on this package.
package s3i_pkg;

  localparam int DW      = 32;       // Q16.16 word
  localparam int PW      = 64;       // 32x32 product
  localparam int CW      = 66;       // signed cofactor
  localparam int CMW     = 64;       // cofactor magnitude
  localparam int TMW     = 96;       // |a| * |cofactor|
  localparam int DSW     = 99;       // signed determinant
  localparam int DMW     = 97;       // determinant magnitude
  localparam int TW      = 31;       // threshold register
  localparam int QB      = 33;       // quotient bits per entry
  localparam int NE      = 6;        // distinct entries
  localparam int DIV_LAT = QB + 2;   // divider latency

  typedef struct packed {
    logic signed [DW-1:0] a00;
    logic signed [DW-1:0] a11;
    logic signed [DW-1:0] a22;
    logic signed [DW-1:0] a12;
    logic signed [DW-1:0] a02;
    logic signed [DW-1:0] a01;
  } mat_t;

  typedef logic [NE-1:0][CW-1:0] cof_vec_t;

  typedef struct packed {
    logic [NE-1:0][CMW-1:0] cmag;
    logic [NE-1:0]          csgn;
    mat_t                   m;
  } pass_t;

  typedef struct packed {
    logic           singular;
    logic           dsgn;
    logic [DMW-1:0] dmag;
    pass_t          p;
  } det_res_t;

  typedef struct packed {
    logic          singular;
    logic [NE-1:0] neg;
    mat_t          m;
  } side_t;

endpackage

/* rtl/core/s3i_if.sv */
// Beat channels of the symmetric 3x3 inverse: matrix in, inverse out.
// Depends on s3i_pkg for the word width.
interface s3i_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [s3i_pkg::DW-1:0] a_00;
  logic signed [s3i_pkg::DW-1:0] a_11;
  logic signed [s3i_pkg::DW-1:0] a_22;
  logic signed [s3i_pkg::DW-1:0] a_12;
  logic signed [s3i_pkg::DW-1:0] a_02;
  logic signed [s3i_pkg::DW-1:0] a_01;
  modport source (output valid, a_00, a_11, a_22, a_12, a_02, a_01, input ready);
  modport sink (input valid, a_00, a_11, a_22, a_12, a_02, a_01, output ready);
endinterface

interface s3i_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [s3i_pkg::DW-1:0] inv_00;
  logic signed [s3i_pkg::DW-1:0] inv_11;
  logic signed [s3i_pkg::DW-1:0] inv_22;
  logic signed [s3i_pkg::DW-1:0] inv_12;
  logic signed [s3i_pkg::DW-1:0] inv_02;
  logic signed [s3i_pkg::DW-1:0] inv_01;
  logic                          ok;
  logic                          saturated;
  modport source (output valid, inv_00, inv_11, inv_22, inv_12, inv_02, inv_01, ok,
                  saturated, input ready);
  modport sink (input valid, inv_00, inv_11, inv_22, inv_12, inv_02, inv_01, ok,
                saturated, output ready);
endinterface

/* rtl/core/s3i_cof.sv */
// Cofactor stages: twelve 32x32 products, then six exact differences.
// Depends on s3i_pkg.
module s3i_cof (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  s3i_pkg::mat_t     in_m,
  output logic              out_valid,
  output s3i_pkg::cof_vec_t out_cof,
  output s3i_pkg::mat_t     out_m
);
  import s3i_pkg::*;

  logic signed [PW-1:0] prod_nxt [2*NE];
  logic signed [PW-1:0] prod_r   [2*NE];
  mat_t                 m1_r;
  logic                 v1_r;
  cof_vec_t             cof_nxt;
  cof_vec_t             cof_r;
  mat_t                 m2_r;
  logic                 v2_r;

  always_comb begin
    prod_nxt[0]  = PW'(in_m.a11) * PW'(in_m.a22);
    prod_nxt[1]  = PW'(in_m.a12) * PW'(in_m.a12);
    prod_nxt[2]  = PW'(in_m.a00) * PW'(in_m.a22);
    prod_nxt[3]  = PW'(in_m.a02) * PW'(in_m.a02);
    prod_nxt[4]  = PW'(in_m.a00) * PW'(in_m.a11);
    prod_nxt[5]  = PW'(in_m.a01) * PW'(in_m.a01);
    prod_nxt[6]  = PW'(in_m.a01) * PW'(in_m.a02);
    prod_nxt[7]  = PW'(in_m.a00) * PW'(in_m.a12);
    prod_nxt[8]  = PW'(in_m.a01) * PW'(in_m.a12);
    prod_nxt[9]  = PW'(in_m.a02) * PW'(in_m.a11);
    prod_nxt[10] = PW'(in_m.a02) * PW'(in_m.a12);
    prod_nxt[11] = PW'(in_m.a01) * PW'(in_m.a22);
  end

  // order: c00 c11 c22 c12 c02 c01
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      cof_nxt[i] = CW'(prod_r[2*i]) - CW'(prod_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      m1_r   <= in_m;
      cof_r  <= cof_nxt;
      m2_r   <= m1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_cof   = cof_r;
  assign out_m     = m2_r;
endmodule

/* rtl/core/s3i_det.sv */
// Determinant stages: magnitudes, split products, signed terms, sum,
// |det| and the singular test. Depends on s3i_pkg.
module s3i_det #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [s3i_pkg::TW-1:0] thr,
  input  logic                in_valid,
  input  s3i_pkg::cof_vec_t   in_cof,
  input  s3i_pkg::mat_t       in_m,
  output logic                out_valid,
  output s3i_pkg::det_res_t   out_res
);
  import s3i_pkg::*;

  localparam int HALF = CMW / 2;

  logic [2:0][DW-1:0]  am_r;
  logic [2:0]          asg_r;
  pass_t               p3_r, p4_r, p5_r, p6_r, p7_r;
  logic [2:0][PW-1:0]  lo_r, hi_r;
  logic [2:0]          ts_r, tn_r;
  logic [2:0][DSW-1:0] tx_r;
  logic signed [DSW-1:0] det_r;
  logic [DMW-1:0]      dmag_r;
  logic                dsgn_r;
  det_res_t            res_r;
  logic [5:0]          v_r;

  pass_t               p3_nxt;
  logic [2:0][DW-1:0]  am_nxt;
  logic [2:0]          asg_nxt;
  logic [2:0]          cidx_sg;
  logic [2:0][CMW-1:0] cidx_mag;
  logic [2:0][TMW-1:0] tmag;
  logic [2:0][DSW-1:0] tx_nxt;
  logic [1:0]          ncnt;
  logic [DMW-1:0]      thr_sh;

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      p3_nxt.csgn[i] = in_cof[i][CW-1];
      p3_nxt.cmag[i] = in_cof[i][CW-1] ? CMW'(-$signed(in_cof[i])) : CMW'(in_cof[i]);
    end
    p3_nxt.m   = in_m;
    asg_nxt[0] = in_m.a00[DW-1];
    asg_nxt[1] = in_m.a01[DW-1];
    asg_nxt[2] = in_m.a02[DW-1];
    am_nxt[0]  = asg_nxt[0] ? DW'(-in_m.a00) : DW'(in_m.a00);
    am_nxt[1]  = asg_nxt[1] ? DW'(-in_m.a01) : DW'(in_m.a01);
    am_nxt[2]  = asg_nxt[2] ? DW'(-in_m.a02) : DW'(in_m.a02);
  end

  // det = a00*c00 + a01*c01 + a02*c02
  assign cidx_mag[0] = p3_r.cmag[0];
  assign cidx_mag[1] = p3_r.cmag[5];
  assign cidx_mag[2] = p3_r.cmag[4];
  assign cidx_sg[0]  = p3_r.csgn[0];
  assign cidx_sg[1]  = p3_r.csgn[5];
  assign cidx_sg[2]  = p3_r.csgn[4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tmag[k]   = {hi_r[k], HALF'(0)} + TMW'(lo_r[k]);
      tx_nxt[k] = ts_r[k] ? ~DSW'(tmag[k]) : DSW'(tmag[k]);
    end
    ncnt   = 2'(tn_r[0]) + 2'(tn_r[1]) + 2'(tn_r[2]);
    thr_sh = DMW'({thr, (2*FRAC_BITS)'(0)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= am_nxt;
      asg_r <= asg_nxt;
      p3_r  <= p3_nxt;
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= PW'(am_r[k]) * PW'(cidx_mag[k][HALF-1:0]);
        hi_r[k] <= PW'(am_r[k]) * PW'(cidx_mag[k][CMW-1:HALF]);
        ts_r[k] <= asg_r[k] ^ cidx_sg[k];
      end
      p4_r   <= p3_r;
      tx_r   <= tx_nxt;
      tn_r   <= ts_r;
      p5_r   <= p4_r;
      det_r  <= $signed(tx_r[0]) + $signed(tx_r[1]) + $signed(tx_r[2]) + DSW'(ncnt);
      p6_r   <= p5_r;
      dsgn_r <= det_r[DSW-1];
      dmag_r <= det_r[DSW-1] ? DMW'(-det_r) : DMW'(det_r);
      p7_r   <= p6_r;
      res_r.singular <= (dmag_r == '0) || (dmag_r < thr_sh);
      res_r.dsgn     <= dsgn_r;
      res_r.dmag     <= dmag_r;
      res_r.p        <= p7_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_res   = res_r;
endmodule

/* rtl/core/s3i_div.sv */
// Pipelined restoring divider: round(|C| * 2^(2F) / |det|), one quotient
// bit per stage, with an overflow flag. Depends on s3i_pkg.
module s3i_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [s3i_pkg::CMW-1:0]  cmag,
  input  logic [s3i_pkg::DMW-1:0]  dmag,
  output logic [s3i_pkg::QB-1:0]   quo,
  output logic                     ovf
);
  import s3i_pkg::*;

  localparam int EW   = DMW + 1;
  localparam int NSH  = 2 * FRAC_BITS + 1;
  localparam int NW0  = CMW + NSH;
  localparam int NW   = ((NW0 > DMW) ? NW0 : DMW) + 1;
  localparam int HW   = NW - QB;
  localparam int CMPW = (HW > EW) ? HW : EW;

  logic [NW-1:0] n_r;
  logic [EW-1:0] e0_r;
  logic [EW-1:0] r_r   [QB+1];
  logic [EW-1:0] e_r   [QB+1];
  logic [QB-1:0] lo_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          ovf_r [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= (NW'(cmag) << NSH) + NW'(dmag);
      e0_r     <= {dmag, 1'b0};
      ovf_r[0] <= CMPW'(n_r[NW-1:QB]) >= CMPW'(e0_r);
      r_r[0]   <= EW'(n_r[NW-1:QB]);
      e_r[0]   <= e0_r;
      lo_r[0]  <= n_r[QB-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [EW:0] rs;
    logic        ge;
    assign rs = {r_r[i], lo_r[i][QB-1-i]};
    assign ge = rs >= {1'b0, e_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i+1]   <= ge ? EW'(rs - {1'b0, e_r[i]}) : EW'(rs);
        q_r[i+1]   <= {q_r[i][QB-2:0], ge};
        e_r[i+1]   <= e_r[i];
        lo_r[i+1]  <= lo_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  assign quo = q_r[QB];
  assign ovf = ovf_r[QB];
endmodule

/* rtl/core/symmetric_3x3_inverse.sv */
// Top level of the symmetric 3x3 inverse pipeline.
// Depends on s3i_pkg, s3i_if, s3i_cof, s3i_det and s3i_div.
//
//  channel  | dir | beat
//  in_ch    | in  | a_00 a_11 a_22 a_12 a_02 a_01 (signed Q16.16)
//  out_ch   | out | inv_00 .. inv_01, ok, saturated
//  cfg_*    | in  | det_threshold, written when cfg_we is high
//
// One beat enters per cycle unless out_ch stalls; the path is 2 cofactor stages,
// 6 determinant stages, 35 divider stages (setup, then one per quotient bit) and the
// output register. Reset clears valid bits and sets the threshold to 655.
// A stall at out_ch freezes the whole pipeline; in_ch.ready drops with it.
module symmetric_3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  s3i_in_if.sink                 in_ch,
  s3i_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [s3i_pkg::TW-1:0] cfg_wdata
);
  import s3i_pkg::*;

  localparam logic [TW-1:0] THR_RESET = TW'(655);

  logic            en;
  logic [TW-1:0]   thr_r;
  mat_t            in_m;
  logic            cof_v;
  cof_vec_t        cof;
  mat_t            cof_m;
  logic            det_v;
  det_res_t        det_res;
  side_t           side_nxt;
  side_t           side_r [DIV_LAT];
  logic [DIV_LAT-1:0] side_v_r;
  logic [NE-1:0][QB-1:0] quo;
  logic [NE-1:0]   qovf;
  logic [NE-1:0][DW-1:0] ent;
  logic [NE-1:0]   sat;
  logic [NE-1:0][DW-1:0] inv_nxt;
  logic            sat_nxt;
  logic            ok_nxt;
  logic [NE-1:0][DW-1:0] inv_r;
  logic            ok_r;
  logic            sat_r;
  logic            out_valid_r;
  side_t           st;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign in_m = '{a00: in_ch.a_00, a11: in_ch.a_11, a22: in_ch.a_22,
                  a12: in_ch.a_12, a02: in_ch.a_02, a01: in_ch.a_01};

  s3i_cof u_cof (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_ch.valid && in_ch.ready), .in_m(in_m),
    .out_valid(cof_v), .out_cof(cof), .out_m(cof_m)
  );

  s3i_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk(clk), .rst_n(rst_n), .en(en), .thr(thr_r),
    .in_valid(cof_v), .in_cof(cof), .in_m(cof_m),
    .out_valid(det_v), .out_res(det_res)
  );

  for (genvar i = 0; i < NE; i++) begin : g_div
    s3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(en), .cmag(det_res.p.cmag[i]), .dmag(det_res.dmag),
      .quo(quo[i]), .ovf(qovf[i])
    );
  end

  always_comb begin
    side_nxt.singular = det_res.singular;
    side_nxt.m        = det_res.p.m;
    for (int i = 0; i < NE; i++) begin
      side_nxt.neg[i] = det_res.p.csgn[i] ^ det_res.dsgn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_v_r <= '0;
    end else if (en) begin
      side_v_r <= {side_v_r[DIV_LAT-2:0], det_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < DIV_LAT; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign st = side_r[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      if (st.neg[i]) begin
        sat[i] = qovf[i] || (quo[i] > QB'(33'h0_8000_0000));
        ent[i] = sat[i] ? 32'h8000_0000 : DW'(-quo[i]);
      end else begin
        sat[i] = qovf[i] || (quo[i][QB-1:DW-1] != '0);
        ent[i] = sat[i] ? 32'h7FFF_FFFF : quo[i][DW-1:0];
      end
    end
    if (st.singular) begin
      inv_nxt = {st.m.a00, st.m.a11, st.m.a22, st.m.a12, st.m.a02, st.m.a01};
      ok_nxt  = 1'b0;
      sat_nxt = 1'b0;
    end else begin
      inv_nxt = {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5]};
      ok_nxt  = 1'b1;
      sat_nxt = |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_v_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r <= inv_nxt;
      ok_r  <= ok_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.inv_00    = inv_r[5];
  assign out_ch.inv_11    = inv_r[4];
  assign out_ch.inv_22    = inv_r[3];
  assign out_ch.inv_12    = inv_r[2];
  assign out_ch.inv_02    = inv_r[1];
  assign out_ch.inv_01    = inv_r[0];
  assign out_ch.ok        = ok_r;
  assign out_ch.saturated = sat_r;

  a_sat_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ok_r || !sat_r))
    else $error("saturated set on a singular beat");

  a_tail_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (en && side_v_r[DIV_LAT-1]) |=> out_valid_r)
    else $error("beat lost at the output register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(side_v_r) && $stable(out_valid_r))
    else $error("pipeline moved during a stall");
endmodule

/* verif/tb_symmetric_3x3_inverse.sv */
`timescale 1ns / 1ps
// Self-checking bench for symmetric_3x3_inverse: exact 128-bit predictor of
// the cofactor inverse, scoreboard on out_ch, random stalls on both channels.
// Depends on s3i_pkg, s3i_if and the RTL of the block.
module tb_symmetric_3x3_inverse;
  import s3i_pkg::*;

  localparam int FB = 16;
  localparam int WATCHDOG = 3000;
  localparam int LATENCY = 44;

  typedef struct packed {
    logic [DW-1:0] inv_00;
    logic [DW-1:0] inv_11;
    logic [DW-1:0] inv_22;
    logic [DW-1:0] inv_12;
    logic [DW-1:0] inv_02;
    logic [DW-1:0] inv_01;
    logic          ok;
    logic          saturated;
  } inverse_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TW-1:0] cfg_wdata;
  logic [TW-1:0] threshold;
  bit calm;
  int errors;
  int idle_cycles;
  int stall_left;
  inverse_t expected_q[$];

  s3i_in_if in_ch();
  s3i_out_if out_ch();

  symmetric_3x3_inverse DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DW-1:0] scale_entry(logic signed [127:0] cof,
                                                logic signed [127:0] det, inout bit sat);
    logic [127:0] num;
    logic [127:0] dm;
    logic [127:0] q;
    bit neg;
    num = (cof < 0) ? -cof : cof;
    num = num << (2 * FB + 1);
    dm = (det < 0) ? -det : det;
    q = (num + dm) / (dm << 1);
    neg = (cof < 0) != (det < 0);
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return DW'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return DW'(q);
  endfunction

  function automatic inverse_t invert_matrix(mat_t m, logic [TW-1:0] thr);
    logic signed [127:0] a00, a11, a22, a12, a02, a01;
    logic signed [127:0] c00, c11, c22, c12, c02, c01, det;
    logic [127:0] dmag;
    logic [127:0] limit;
    inverse_t r;
    bit sat;
    a00 = $signed(m.a00);
    a11 = $signed(m.a11);
    a22 = $signed(m.a22);
    a12 = $signed(m.a12);
    a02 = $signed(m.a02);
    a01 = $signed(m.a01);
    c00 = a11 * a22 - a12 * a12;
    c11 = a00 * a22 - a02 * a02;
    c22 = a00 * a11 - a01 * a01;
    c12 = a01 * a02 - a00 * a12;
    c02 = a01 * a12 - a02 * a11;
    c01 = a02 * a12 - a01 * a22;
    det = a00 * c00 + a01 * c01 + a02 * c02;
    dmag = (det < 0) ? -det : det;
    limit = 128'(thr) << (2 * FB);
    sat = 1'b0;
    if (det == 0 || dmag < limit) begin
      r = '{m.a00, m.a11, m.a22, m.a12, m.a02, m.a01, 1'b0, 1'b0};
    end else begin
      r.inv_00 = scale_entry(c00, det, sat);
      r.inv_11 = scale_entry(c11, det, sat);
      r.inv_22 = scale_entry(c22, det, sat);
      r.inv_12 = scale_entry(c12, det, sat);
      r.inv_02 = scale_entry(c02, det, sat);
      r.inv_01 = scale_entry(c01, det, sat);
      r.ok = 1'b1;
      r.saturated = sat;
    end
    return r;
  endfunction

  // input monitor: predict on every accepted beat
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_q.push_back(invert_matrix('{in_ch.a_00, in_ch.a_11, in_ch.a_22,
                                           in_ch.a_12, in_ch.a_02, in_ch.a_01},
                                         threshold));
  end

  // result checker
  always @(posedge clk) begin
    inverse_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.inv_00 !== e.inv_00) begin
          $error("inv_00 exp %h got %h", e.inv_00, out_ch.inv_00); errors++;
        end
        if (out_ch.inv_11 !== e.inv_11) begin
          $error("inv_11 exp %h got %h", e.inv_11, out_ch.inv_11); errors++;
        end
        if (out_ch.inv_22 !== e.inv_22) begin
          $error("inv_22 exp %h got %h", e.inv_22, out_ch.inv_22); errors++;
        end
        if (out_ch.inv_12 !== e.inv_12) begin
          $error("inv_12 exp %h got %h", e.inv_12, out_ch.inv_12); errors++;
        end
        if (out_ch.inv_02 !== e.inv_02) begin
          $error("inv_02 exp %h got %h", e.inv_02, out_ch.inv_02); errors++;
        end
        if (out_ch.inv_01 !== e.inv_01) begin
          $error("inv_01 exp %h got %h", e.inv_01, out_ch.inv_01); errors++;
        end
        if (out_ch.ok !== e.ok) begin
          $error("ok exp %b got %b", e.ok, out_ch.ok); errors++;
        end
        if (out_ch.saturated !== e.saturated) begin
          $error("saturated exp %b got %b", e.saturated, out_ch.saturated); errors++;
        end
      end
    end
  end

  // result-side backpressure in bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 3) begin
      out_ch.ready <= $urandom_range(0, 1);
      stall_left <= $urandom_range(1, 19);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_matrix(mat_t m);
    in_ch.valid <= 1'b1;
    in_ch.a_00 <= m.a00;
    in_ch.a_11 <= m.a11;
    in_ch.a_22 <= m.a22;
    in_ch.a_12 <= m.a12;
    in_ch.a_02 <= m.a02;
    in_ch.a_01 <= m.a01;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!calm && $urandom_range(0, 9) < 2) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [TW-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    threshold <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DW-1:0] q16(int whole);
    return DW'(whole) << FB;
  endfunction

  function automatic logic [DW-1:0] small_word(int span);
    return DW'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int kind;
    logic [DW-1:0] u0, u1, u2;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        m = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      2, 3: begin
        m = '{small_word(1 << 19), small_word(1 << 19), small_word(1 << 19),
              small_word(1 << 19), small_word(1 << 19), small_word(1 << 19)};
      end
      4, 5: begin
        m = '{small_word(100 << 16), small_word(100 << 16), small_word(100 << 16),
              small_word(1 << 16), small_word(1 << 16), small_word(1 << 16)};
      end
      6, 7: begin
        // rank-one u*u' plus a few raw bits of noise
        u0 = small_word(2048);
        u1 = small_word(2048);
        u2 = small_word(2048);
        m.a00 = ((u0 * u0) << 2) + small_word(3);
        m.a11 = ((u1 * u1) << 2) + small_word(3);
        m.a22 = ((u2 * u2) << 2) + small_word(3);
        m.a12 = ((u1 * u2) << 2) + small_word(3);
        m.a02 = ((u0 * u2) << 2) + small_word(3);
        m.a01 = ((u0 * u1) << 2) + small_word(3);
      end
      default: begin
        // tiny matrices: diagonal within +-3000, off-diagonal within +-200 raw LSBs
        m = '{small_word(3000), small_word(3000), small_word(3000),
              small_word(200), small_word(200), small_word(200)};
      end
    endcase
    return m;
  endfunction

  task automatic test_directed();
    send_matrix('{q16(1), q16(1), q16(1), 0, 0, 0});
    send_matrix('{q16(2), q16(4), q16(-8), 0, 0, 0});
    send_matrix('{0, 0, 0, 0, 0, 0});
    send_matrix('{q16(1), q16(1), 32'd655, 0, 0, 0});
    send_matrix('{q16(1), q16(1), 32'd654, 0, 0, 0});
    send_matrix('{q16(1), q16(-1), 32'd655, 0, 0, 0});
    send_matrix('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_matrix('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_matrix('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0});
    send_matrix('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_matrix('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0});
    send_matrix('{32'd1, 32'd1, 32'd1, 0, 0, 0});
    send_matrix('{q16(1), q16(1), 32'd1000, 0, 0, 0});
    send_matrix('{q16(2), q16(2), q16(2), q16(1), q16(1), q16(1)});
    send_matrix('{q16(1), q16(1), q16(1), q16(1), q16(1), q16(1)});
    send_matrix('{q16(4), q16(5), q16(6), q16(-1), q16(2), q16(-3)});
    send_matrix('{q16(3), 32'h0000_8000, q16(-7), 32'h0000_4000, 32'hFFFF_C000, q16(1)});
    send_matrix('{0, 0, 0, q16(1), q16(1), q16(1)});
    send_matrix('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0});
  endtask

  task automatic test_threshold_extremes();
    write_threshold('0);
    send_matrix('{0, 0, 0, 0, 0, 0});
    send_matrix('{32'd1, 32'd1, 32'd1, 0, 0, 0});
    send_matrix('{q16(1), q16(1), q16(1), 0, 0, 0});
    write_threshold({TW{1'b1}});
    send_matrix('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0});
    send_matrix('{q16(1), q16(1), q16(1), 0, 0, 0});
  endtask

  task automatic test_random(int count, logic [TW-1:0] thr);
    write_threshold(thr);
    repeat (count) send_matrix(random_matrix());
  endtask

  task automatic test_pause_midstream();
    repeat (40) send_matrix(random_matrix());
    wait_drained();
    repeat (40) send_matrix(random_matrix());
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    threshold = 31'd655;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.a_00 <= '0;
    in_ch.a_11 <= '0;
    in_ch.a_22 <= '0;
    in_ch.a_12 <= '0;
    in_ch.a_02 <= '0;
    in_ch.a_01 <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_threshold_extremes();
    test_random(400, 31'd655);
    test_random(350, 31'd0);
    test_random(150, {TW{1'b1}});
    test_random(350, TW'($urandom_range(0, 1 << 20)));
    test_pause_midstream();
    wait_drained();
    calm = 1'b1;
    test_random(300, 31'd655);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
